[hw/rtl/stip_pkg.sv]
// Package for the string-to-integer parser: widths, parse phases,
// status codes, register indexes and character constants. No dependencies.
package stip_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_LENGTH  = 4096;
  localparam int POS_W       = $clog2(MAX_LENGTH + 1);
  localparam int OUT_VALUE_W = 64;
  localparam int END_W       = 13;
  localparam int BASE_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SUM_W       = VALUE_WIDTH + BASE_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_PREFIX_EN = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_BAD_BASE  = 2'd3;

  // Bases that the prefix logic picks.
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_2    = 6'd2;
  localparam logic [BASE_W-1:0] BASE_8    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_10   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_16   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] UPPER_OFS = 8'd55;
  localparam logic [7:0] LOWER_OFS = 8'd87;

  typedef enum logic [6:0] {
    PH_WS     = 7'b0000001,
    PH_SIGN   = 7'b0000010,
    PH_ZERO   = 7'b0000100,
    PH_PREFIX = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_BAD    = 7'b1000000
  } phase_t;

  // Digit step result handed from the multiply-add unit to the control.
  typedef struct packed {
    logic                   digit_ok;  // valid digit below the base
    logic                   fits;      // acc * base + digit stays in range
    logic [VALUE_WIDTH-1:0] sum;
  } mac_res_t;

endpackage

[hw/rtl/stip_mac.sv]
// Digit decode and multiply-add step of the parser.
// Depends on stip_pkg.
module stip_mac import stip_pkg::*; (
  input  logic [7:0]             character,
  input  logic [BASE_W-1:0]      digit_base,
  input  logic [VALUE_WIDTH-1:0] acc,
  output mac_res_t               res
);

  logic               is_digit;
  logic [DIGIT_W-1:0] digit;
  logic [7:0]         digit_wide;
  logic [SUM_W-1:0]   sum_wide;

  always_comb begin
    is_digit   = 1'b1;
    digit_wide = 8'd0;
    if (character >= CH_ZERO && character <= CH_NINE) begin
      digit_wide = character - CH_ZERO;
    end else if (character >= CH_UA && character <= CH_UZ) begin
      digit_wide = character - UPPER_OFS;
    end else if (character >= CH_LA && character <= CH_LZ) begin
      digit_wide = character - LOWER_OFS;
    end else begin
      is_digit = 1'b0;
    end
    digit = digit_wide[DIGIT_W-1:0];
  end

  // Exact product: overflow iff the wide sum exceeds the value mask.
  assign sum_wide = SUM_W'(acc) * SUM_W'(digit_base) + SUM_W'(digit);

  assign res.digit_ok = is_digit && (digit_base >= BASE_2) &&
                        (DIGIT_W'(digit) < digit_base);
  assign res.fits     = ~|sum_wide[SUM_W-1:VALUE_WIDTH];
  assign res.sum      = sum_wide[VALUE_WIDTH-1:0];

endmodule

[hw/rtl/string_to_integer_parser.sv]
// A NUL taken into the input register moves its result to out_* via the output register.
// Throughput: one character per cycle, except while a NUL waits on a full output register; the
//   per-character multiply-add by the base (stip_mac) sits between the input and parse state registers.
// Reset (synchronous, rst_n low): parse state cleared, base 0, unsigned_mode 0,
//   binary_prefix_enable 1; input and output stages empty.
// Depends on stip_pkg and stip_mac.
module string_to_integer_parser import stip_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_character,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_VALUE_W-1:0] out_value,
  output logic [1:0]             out_status,
  output logic [END_W-1:0]       out_end_position,
  output logic                   out_length_overflow,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [BASE_W-1:0] cfg_base_r;
  logic              cfg_unsigned_r;
  logic              cfg_bin_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r     <= BASE_AUTO;
      cfg_unsigned_r <= 1'b0;
      cfg_bin_en_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:          cfg_base_r     <= cfg_data[BASE_W-1:0];
        CFG_UNSIGNED_MODE: cfg_unsigned_r <= cfg_data[0];
        CFG_BIN_PREFIX_EN: cfg_bin_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_is_nul;
  logic       s1_fire;
  logic       out_valid_r;

  assign s1_is_nul = (s1_char_r == CH_NUL);
  // A NUL waits only while the result register is full and not drained.
  assign s1_fire   = s1_valid_r && (!s1_is_nul || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_character;
    end
  end

  // Parse state.
  phase_t                 phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       endm_r, endm_nxt;
  logic                   dseen_r, dseen_nxt;
  logic                   len_r, len_nxt;

  // Base in effect: sampled from the register at the first character.
  logic [BASE_W-1:0] base_eff;
  logic              base_bad;
  logic [POS_W-1:0]  pos_inc;

  assign base_eff = (pos_r == '0 && phase_r == PH_WS) ? cfg_base_r : base_r;
  assign base_bad = (base_eff == 6'd1) || (base_eff > BASE_MAX);
  assign pos_inc  = pos_r + POS_W'(1);

  // Decide what this character does before any digit step.
  phase_t            phase_a;
  logic [BASE_W-1:0] base_a;
  logic              neg_a;
  logic              zero_a;   // leading zero taken as a digit
  logic              do_digit;
  logic              in_range;
  logic              is_space;

  assign in_range = (pos_r < POS_W'(MAX_LENGTH));
  assign is_space = (s1_char_r == CH_SPACE) ||
                    (s1_char_r >= CH_TAB && s1_char_r <= CH_CR);

  always_comb begin
    phase_a  = phase_r;
    base_a   = base_eff;
    neg_a    = neg_r;
    zero_a   = 1'b0;
    do_digit = 1'b0;
    case (phase_r)
      PH_WS, PH_SIGN: begin
        if (phase_r == PH_WS && base_bad) begin
          phase_a = PH_BAD;
        end else if (phase_r == PH_WS && is_space) begin
          phase_a = PH_WS;
        end else if (phase_r == PH_WS && s1_char_r == CH_MINUS) begin
          neg_a   = 1'b1;
          phase_a = PH_SIGN;
        end else if (phase_r == PH_WS && s1_char_r == CH_PLUS) begin
          phase_a = PH_SIGN;
        end else if (s1_char_r == CH_ZERO && (base_eff == BASE_AUTO ||
                     base_eff == BASE_16 || base_eff == BASE_2)) begin
          zero_a  = 1'b1;
          phase_a = PH_ZERO;
        end else begin
          if (base_eff == BASE_AUTO) begin
            base_a = BASE_10;
          end
          do_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if ((s1_char_r == CH_LX || s1_char_r == CH_UX) &&
            (base_eff == BASE_AUTO || base_eff == BASE_16)) begin
          base_a  = BASE_16;
          phase_a = PH_PREFIX;
        end else if ((s1_char_r == CH_LB || s1_char_r == CH_UB) && cfg_bin_en_r &&
                     (base_eff == BASE_AUTO || base_eff == BASE_2)) begin
          base_a  = BASE_2;
          phase_a = PH_PREFIX;
        end else begin
          if (base_eff == BASE_AUTO) begin
            base_a = BASE_8;
          end
          do_digit = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: ;
    endcase
  end

  mac_res_t mac;

  stip_mac u_mac (
    .character  (s1_char_r),
    .digit_base (base_a),
    .acc        (acc_r),
    .res        (mac)
  );

  // Next state: clear on NUL, hold past the length limit, else advance.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    base_nxt  = base_eff;
    pos_nxt   = pos_r;
    endm_nxt  = endm_r;
    dseen_nxt = dseen_r;
    len_nxt   = len_r;
    if (s1_is_nul) begin
      phase_nxt = PH_WS;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      base_nxt  = BASE_AUTO;
      pos_nxt   = '0;
      endm_nxt  = '0;
      dseen_nxt = 1'b0;
      len_nxt   = 1'b0;
    end else if (!in_range) begin
      len_nxt = 1'b1;
    end else begin
      pos_nxt   = pos_inc;
      phase_nxt = phase_a;
      base_nxt  = base_a;
      neg_nxt   = neg_a;
      if (zero_a) begin
        dseen_nxt = 1'b1;
        endm_nxt  = pos_inc;
        acc_nxt   = '0;
      end
      if (do_digit) begin
        if (!mac.digit_ok) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_DIGITS;
          dseen_nxt = 1'b1;
          endm_nxt  = pos_inc;
          // Once saturated, keep consuming the run without accumulating.
          if (!ovf_r) begin
            if (mac.fits) begin
              acc_nxt = mac.sum;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      base_r  <= BASE_AUTO;
      pos_r   <= '0;
      endm_r  <= '0;
      dseen_r <= 1'b0;
      len_r   <= 1'b0;
    end else if (s1_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      base_r  <= base_nxt;
      pos_r   <= pos_nxt;
      endm_r  <= endm_nxt;
      dseen_r <= dseen_nxt;
      len_r   <= len_nxt;
    end
  end

  // Result formatting at the NUL: saturate by mode and sign.
  localparam logic [VALUE_WIDTH-1:0] VAL_MASK = '1;
  localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH-1:0] acc_neg;
  logic [VALUE_WIDTH-1:0] val_res;
  logic [1:0]             status_res;
  logic [END_W-1:0]       endp_res;
  logic                   sat;

  assign acc_neg = VAL_MASK & (~acc_r + VALUE_WIDTH'(1));

  always_comb begin
    val_res    = '0;
    endp_res   = '0;
    status_res = ST_OK;
    sat        = ovf_r;
    if (phase_r == PH_BAD || (phase_r == PH_WS && base_bad)) begin
      status_res = ST_BAD_BASE;
    end else if (!dseen_r) begin
      status_res = ST_NO_DIGITS;
    end else begin
      endp_res = END_W'(endm_r);
      if (cfg_unsigned_r) begin
        val_res = ovf_r ? VAL_MASK : (neg_r ? acc_neg : acc_r);
      end else begin
        if (!ovf_r) begin
          sat = neg_r ? (acc_r[VALUE_WIDTH-1] && |acc_r[VALUE_WIDTH-2:0])
                      : acc_r[VALUE_WIDTH-1];
        end
        if (sat) begin
          val_res = neg_r ? SMIN : SMAX;
        end else begin
          val_res = neg_r ? acc_neg : acc_r;
        end
      end
      status_res = sat ? ST_OVERFLOW : ST_OK;
    end
  end

  // Output register: load on a NUL transfer out of the input stage.
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic [1:0]             out_status_r;
  logic [END_W-1:0]       out_endp_r;
  logic                   out_len_r;

  assign out_load = s1_fire && s1_is_nul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= val_res;
      out_status_r <= status_res;
      out_endp_r   <= endp_res;
      out_len_r    <= len_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_value           = OUT_VALUE_W'(out_value_r);
  assign out_status          = out_status_r;
  assign out_end_position    = out_endp_r;
  assign out_length_overflow = out_len_r;

endmodule

[bench/tb_string_to_integer_parser.sv]
`timescale 1ns / 1ps
// Self-checking testbench for string_to_integer_parser: directed and random strings,
// checked against a behavioral predictor. Depends on stip_pkg and the parser RTL.
module tb_string_to_integer_parser;
  import stip_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int IDLE_SETTLE    = 4;     // cycles to let the pipeline empty after a drain
  localparam int RANDOM_ITEMS   = 420;   // characters in the random part
  localparam int MAX_WAIT       = 18;    // longest per-item gap on either side
  localparam int REPORT_LIMIT   = 10;

  localparam logic [63:0] VAL_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);
  localparam logic [63:0] SIGNED_MAX = VAL_MASK >> 1;
  localparam int          NOT_DIGIT  = 99;

  // Out-of-range bases used to exercise rejection.
  localparam logic [BASE_W-1:0] BASE_ONE       = 6'd1;
  localparam logic [BASE_W-1:0] BASE_FIRST_BAD = 6'd37;
  localparam logic [BASE_W-1:0] BASE_TOP       = 6'd63;

  typedef struct {
    logic [OUT_VALUE_W-1:0] value;
    logic [1:0]             status;
    logic [END_W-1:0]       end_pos;
    logic                   len_ovf;
  } conversion_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_character = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_VALUE_W-1:0] out_value;
  logic [1:0]            out_status;
  logic [END_W-1:0]      out_end_position;
  logic                  out_length_overflow;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  string_to_integer_parser uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_character        (in_character),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_value           (out_value),
    .out_status          (out_status),
    .out_end_position    (out_end_position),
    .out_length_overflow (out_length_overflow),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Shadow copies of the registers, as the block should hold them.
  logic [BASE_W-1:0] base_reg;
  logic              unsigned_reg;
  logic              binpfx_reg;

  // Scanner state of the predictor.
  phase_t            scan_phase;
  logic [63:0]       scan_acc;
  logic              scan_neg;
  logic              scan_ovf;
  logic [BASE_W-1:0] scan_base;
  int unsigned       scan_pos;
  int unsigned       scan_end;
  logic              scan_digits;
  logic              scan_too_long;

  conversion_t expected_conversions[$];

  // Knobs shared by the test tasks and the two channel drivers.
  int gap_max = MAX_WAIT;
  int stall_max = MAX_WAIT;
  int hold_request = 0;
  int ready_wait = 0;

  int mismatches = 0;
  int results_checked = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int reg_writes = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_scan();
    scan_phase    = PH_WS;
    scan_acc      = '0;
    scan_neg      = 1'b0;
    scan_ovf      = 1'b0;
    scan_base     = BASE_AUTO;
    scan_pos      = 0;
    scan_end      = 0;
    scan_digits   = 1'b0;
    scan_too_long = 1'b0;
  endfunction

  function automatic int digit_of_char(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_UA && c <= CH_UZ) return int'(c) - int'(UPPER_OFS);
    if (c >= CH_LA && c <= CH_LZ) return int'(c) - int'(LOWER_OFS);
    return NOT_DIGIT;
  endfunction

  function automatic logic base_rejected(logic [BASE_W-1:0] b);
    return (b == BASE_ONE) || (b > BASE_MAX);
  endfunction

  // Take one digit of the current base, or close the conversion.
  function automatic void accumulate(logic [7:0] c, int unsigned pos);
    int          d;
    logic [63:0] limit;
    d = digit_of_char(c);
    if (scan_base < 2 || d >= scan_base) begin
      scan_phase = PH_DONE;
      return;
    end
    scan_phase  = PH_DIGITS;
    scan_digits = 1'b1;
    scan_end    = pos + 1;
    if (!scan_ovf) begin
      limit = (VAL_MASK - 64'(d)) / 64'(scan_base);
      if (scan_acc > limit) scan_ovf = 1'b1;
      else scan_acc = (scan_acc * 64'(scan_base) + 64'(d)) & VAL_MASK;
    end
  endfunction

  // First character after whitespace and sign: a leading zero may open a prefix.
  function automatic void take_first(logic [7:0] c, int unsigned pos);
    if (c == CH_ZERO &&
        (scan_base == BASE_AUTO || scan_base == BASE_16 || scan_base == BASE_2)) begin
      scan_digits = 1'b1;
      scan_end    = pos + 1;
      scan_acc    = '0;
      scan_phase  = PH_ZERO;
      return;
    end
    if (scan_base == BASE_AUTO) scan_base = BASE_10;
    accumulate(c, pos);
  endfunction

  function automatic void take_after_zero(logic [7:0] c, int unsigned pos);
    logic auto_base;
    auto_base = (scan_base == BASE_AUTO);
    if ((c == CH_LX || c == CH_UX) && (auto_base || scan_base == BASE_16)) begin
      scan_base  = BASE_16;
      scan_phase = PH_PREFIX;
    end else if ((c == CH_LB || c == CH_UB) && binpfx_reg &&
                 (auto_base || scan_base == BASE_2)) begin
      scan_base  = BASE_2;
      scan_phase = PH_PREFIX;
    end else begin
      if (auto_base) scan_base = BASE_8;
      accumulate(c, pos);
    end
  endfunction

  function automatic void scan_char(logic [7:0] c, int unsigned pos);
    case (scan_phase)
      PH_WS: begin
        if (base_rejected(scan_base)) begin
          scan_phase = PH_BAD;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          // skip leading whitespace
        end else if (c == CH_MINUS) begin
          scan_neg   = 1'b1;
          scan_phase = PH_SIGN;
        end else if (c == CH_PLUS) begin
          scan_phase = PH_SIGN;
        end else begin
          take_first(c, pos);
        end
      end
      PH_SIGN:   take_first(c, pos);
      PH_ZERO:   take_after_zero(c, pos);
      PH_PREFIX: begin
        if (digit_of_char(c) < scan_base) accumulate(c, pos);
        else scan_phase = PH_DONE;
      end
      PH_DIGITS: accumulate(c, pos);
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted character; a NUL yields a conversion.
  function automatic logic convert_char(logic [7:0] c, output conversion_t r);
    logic ovf;
    r.value   = '0;
    r.status  = ST_OK;
    r.end_pos = '0;
    r.len_ovf = 1'b0;
    if (scan_pos == 0 && scan_phase == PH_WS) scan_base = base_reg;
    if (c != CH_NUL) begin
      if (scan_pos >= MAX_LENGTH) begin
        scan_too_long = 1'b1;
      end else begin
        scan_char(c, scan_pos);
        scan_pos++;
      end
      return 1'b0;
    end
    if (scan_phase == PH_BAD || (scan_phase == PH_WS && base_rejected(scan_base))) begin
      r.status = ST_BAD_BASE;
    end else if (!scan_digits) begin
      r.status = ST_NO_DIGITS;
    end else begin
      ovf       = scan_ovf;
      r.end_pos = END_W'(scan_end);
      if (unsigned_reg) begin
        if (ovf) r.value = VAL_MASK;
        else r.value = scan_neg ? ((64'd0 - scan_acc) & VAL_MASK) : scan_acc;
      end else begin
        if (!ovf) ovf = scan_neg ? (scan_acc > SIGNED_MAX + 64'd1) : (scan_acc > SIGNED_MAX);
        if (ovf) r.value = scan_neg ? (SIGNED_MAX + 64'd1) : SIGNED_MAX;
        else r.value = scan_neg ? ((64'd0 - scan_acc) & VAL_MASK) : scan_acc;
      end
      r.status = ovf ? ST_OVERFLOW : ST_OK;
    end
    r.len_ovf = scan_too_long;
    clear_scan();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  function automatic int draw_wait(int limit);
    if (limit <= 0 || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, limit);
  endfunction

  // Offer one character and hold it until the transfer. Valid stays high after
  // the transfer so that a zero gap gives back-to-back items.
  task automatic send_char(input logic [7:0] c);
    int          gap;
    conversion_t res;
    gap = draw_wait(gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    if (convert_char(c, res)) expected_conversions.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
    strings_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] chars[$]);
    foreach (chars[i]) send_char(chars[i]);
    send_char(CH_NUL);
    strings_sent++;
  endtask

  // Drop valid, wait for every outstanding conversion, then let the pipe empty.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_BASE:          base_reg = data;
      CFG_UNSIGNED_MODE: unsigned_reg = data[0];
      CFG_BIN_PREFIX_EN: binpfx_reg = data[0];
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers; the flag registers get random upper bits,
  // which the block must ignore.
  task automatic configure(input logic [BASE_W-1:0] b, input logic uns, input logic binpfx);
    write_reg(CFG_BASE, b);
    write_reg(CFG_UNSIGNED_MODE, {5'($urandom()), uns});
    write_reg(CFG_BIN_PREFIX_EN, {5'($urandom()), binpfx});
  endtask

  // Receiver: draw a stall after each transfer, or honor a long hold-off when
  // a test asks for one. One assignment to out_ready per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_valid && out_ready) check_conversion();
      if (hold_request > 0) begin
        ready_wait   = hold_request;
        hold_request = 0;
      end else if (out_valid && out_ready) begin
        ready_wait = draw_wait(stall_max);
      end else if (ready_wait > 0) begin
        ready_wait--;
      end
      out_ready <= (ready_wait == 0);
    end
  end

  task automatic check_conversion();
    conversion_t want;
    if (expected_conversions.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("ERROR: result with nothing expected: value=%h status=%0d end=%0d len_ovf=%0b",
                 out_value, out_status, out_end_position, out_length_overflow);
      return;
    end
    want = expected_conversions.pop_front();
    results_checked++;
    if (out_value !== want.value || out_status !== want.status ||
        out_end_position !== want.end_pos || out_length_overflow !== want.len_ovf) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("ERROR: result %0d mismatch at %0t", results_checked, $realtime);
        $display("  expected value=%h status=%0d end=%0d len_ovf=%0b",
                 want.value, want.status, want.end_pos, want.len_ovf);
        $display("  actual   value=%h status=%0d end=%0d len_ovf=%0b",
                 out_value, out_status, out_end_position, out_length_overflow);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random string generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return 8'(CH_ZERO + d);
    return $urandom_range(0, 1) ? 8'(CH_UA + d - 10) : 8'(CH_LA + d - 10);
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 11))
      0, 1:    return BASE_AUTO;
      2:       return BASE_2;
      3:       return BASE_8;
      4:       return BASE_10;
      5:       return BASE_16;
      6:       return BASE_MAX;
      7:       return BASE_ONE;
      8:       return $urandom_range(0, 1) ? BASE_FIRST_BAD : BASE_TOP;
      default: return BASE_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Well-formed number text for the current base, with random content and
  // an occasional junk tail.
  task automatic send_random_number();
    logic [7:0] chars[$];
    int         digits;
    int         radix;
    radix = (base_rejected(base_reg) || base_reg == BASE_AUTO) ? 10 : int'(base_reg);
    repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0) chars.push_back(pick_space());
    case ($urandom_range(0, 3))
      0:       chars.push_back(CH_MINUS);
      1:       chars.push_back(CH_PLUS);
      default: ;
    endcase
    if (base_reg == BASE_AUTO) begin
      case ($urandom_range(0, 3))
        0: begin
          chars.push_back(CH_ZERO);
          chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          radix = 16;
        end
        1: begin
          chars.push_back(CH_ZERO);
          chars.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
          radix = 2;
        end
        2: begin
          chars.push_back(CH_ZERO);
          radix = 8;
        end
        default: chars.push_back(digit_char($urandom_range(1, 9)));
      endcase
    end else if (base_reg == BASE_16 && $urandom_range(0, 1)) begin
      chars.push_back(CH_ZERO);
      chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end else if (base_reg == BASE_2 && $urandom_range(0, 1)) begin
      chars.push_back(CH_ZERO);
      chars.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
    end
    // Mostly short runs; now and then long enough to overflow even in base 2.
    digits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 6);
    repeat (digits) chars.push_back(digit_char($urandom_range(0, radix - 1)));
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(1, 255)));
    send_bytes(chars);
  endtask

  task automatic send_noise();
    logic [7:0] chars[$];
    repeat ($urandom_range(0, 8)) chars.push_back(8'($urandom_range(1, 255)));
    send_bytes(chars);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Registers at their reset values: auto base, signed, binary prefix on.
  task automatic test_reset_defaults();
    send_text("123");
    send_text("");
    send_text("0x1F");
    send_text("0b101");
    send_text("017");
    settle_idle();
  endtask

  // Signed and unsigned limits, saturation, whitespace, signs, junk bytes.
  task automatic test_limits_and_signs();
    configure(BASE_10, 1'b0, 1'b1);
    send_text("9223372036854775807");
    send_text("-9223372036854775808");
    send_text("9223372036854775808");
    send_text("-9223372036854775809");
    send_text("18446744073709551616");
    send_text("\040\011\012\013\014\015+42");
    send_text("-");
    send_text("abc");
    send_text("12\3773");
    settle_idle();
    configure(BASE_AUTO, 1'b1, 1'b1);
    send_text("-1");
    send_text("18446744073709551615");
    send_text("99999999999999999999");
    send_text("0xfFfFfFfFfFfFfFfF");
    settle_idle();
  endtask

  // Prefixes with and without digits, octal fallback, disabled binary prefix.
  task automatic test_prefix_rules();
    send_text("0x");
    send_text("0b2");
    send_text("08");
    settle_idle();
    configure(BASE_MAX, 1'b0, 1'b0);
    send_text("zZ");
    send_text("-Zz!");
    settle_idle();
    configure(BASE_AUTO, 1'b0, 1'b0);
    send_text("0b1");
    settle_idle();
    configure(BASE_16, 1'b0, 1'b1);
    send_text("0x");
    send_text("0Xg");
    settle_idle();
    configure(BASE_2, 1'b1, 1'b1);
    send_text("0b");
    send_text("-0b11");
    settle_idle();
    configure(BASE_8, 1'b0, 1'b1);
    send_text("0x7");
    settle_idle();
  endtask

  task automatic test_rejected_bases();
    configure(BASE_ONE, 1'b0, 1'b1);
    send_text("123");
    settle_idle();
    configure(BASE_FIRST_BAD, 1'b1, 1'b0);
    send_text("");
    settle_idle();
    configure(BASE_TOP, 1'b0, 1'b1);
    send_text("7");
    settle_idle();
  endtask

  // Groups of random strings, each under a fresh register setting and pacing.
  task automatic test_random_strings();
    int first_char;
    first_char = chars_sent;
    while (chars_sent - first_char < RANDOM_ITEMS) begin
      settle_idle();
      configure(pick_base(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0:       begin gap_max = 0;        stall_max = 0;        end
        1:       begin gap_max = MAX_WAIT; stall_max = 0;        end
        2:       begin gap_max = 0;        stall_max = MAX_WAIT; end
        default: begin gap_max = MAX_WAIT; stall_max = MAX_WAIT; end
      endcase
      repeat (8) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_random_number();
      end
    end
    settle_idle();
    gap_max   = MAX_WAIT;
    stall_max = MAX_WAIT;
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // fills and stalls its input; then pause the sender until all results land.
  task automatic test_output_backpressure();
    gap_max      = 0;
    stall_max    = 0;
    hold_request = 400;
    repeat (40) send_text("5");
    settle_idle();
    gap_max   = MAX_WAIT;
    stall_max = MAX_WAIT;
    repeat (3) begin
      repeat (4) send_random_number();
      settle_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    base_reg     = BASE_AUTO;
    unsigned_reg = 1'b0;
    binpfx_reg   = 1'b1;
    clear_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_limits_and_signs();
    test_prefix_rules();
    test_rejected_bases();
    test_random_strings();
    test_output_backpressure();
    settle_idle();

    $display("Ran %0d strings (%0d characters) over %0d register writes;",
             strings_sent, chars_sent, reg_writes);
    $display("checked %0d conversions, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_conversions.size() == 0) begin
      $display("string_to_integer_parser test passed");
    end else begin
      $display("string_to_integer_parser test failed");
    end
    $finish;
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_conversions.size());
    $display("string_to_integer_parser test failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/stip_pkg.sv
hw/rtl/stip_mac.sv
hw/rtl/string_to_integer_parser.sv
bench/tb_string_to_integer_parser.sv
